/* hw/rtl/fsc_pkg.sv */
// Shared types and constants of the frustum sphere cull block.
package fsc_pkg;

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 4;
   localparam int WORD_W      = 32;
   localparam int RADIUS_W    = 31;
   localparam int COUNT_W     = 16;
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 40;
   localparam int NUM_PLANES  = 6;
   localparam int MATRIX_WORDS = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

   localparam logic [2:0] LAST_PLANE = 3'd5;
   localparam logic [1:0] LAST_WORD  = 2'd3;
   localparam logic [1:0] LAST_AXIS  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BLD_RDW,
      ST_BLD_RDV,
      ST_BLD_RAW,
      ST_BLD_MAX,
      ST_BLD_NORM,
      ST_BLD_SQ,
      ST_BLD_SQRT0,
      ST_BLD_SQRT,
      ST_BLD_DIV0,
      ST_BLD_DIV,
      ST_BLD_DST,
      ST_BLD_ZERO,
      ST_BLD_WR,
      ST_TST_RD,
      ST_TST_MAC,
      ST_TST_CMP,
      ST_TST_OUT
   } state_type;

   typedef struct packed {
      logic       load_word;
      logic       capture;
      logic       rd_w;
      logic       rd_v;
      logic       lat_w;
      logic       lat_raw;
      logic       init_max;
      logic       norm_step;
      logic       sq_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_store;
      logic       plane_zero;
      logic       plane_write;
      logic       clear_counts;
      logic       test_rd;
      logic       mac_step;
      logic       test_cmp;
      logic       emit;
      logic [2:0] plane;
      logic [1:0] step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic norm_ok;
      logic mx_zero;
      logic sqrt_last;
      logic div_last;
      logic culled;
      logic slot_free;
   } dp_status_type;

endpackage

/* hw/rtl/fsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/fsc_ctrl.sv */
// Sequencer for matrix loads, plane builds and sphere tests.
module fsc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [fsc_pkg::CMD_W-1:0]     req_tuser,
   output logic                          req_tready,
   input  fsc_pkg::dp_status_type        status,
   output fsc_pkg::ctrl_cmd_type         cmd
);

   fsc_pkg::state_type state_ff, state_in;
   logic [2:0] p_ff, p_in;
   logic [1:0] j_ff, j_in;
   logic       accept;

   assign accept = req_tvalid && (state_ff == fsc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsc_pkg::ST_IDLE;
         p_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      j_in     = j_ff;
      case (state_ff)
         fsc_pkg::ST_IDLE: begin
            p_in = '0;
            j_in = '0;
            if (accept) begin
               if (req_tuser == fsc_pkg::CMD_BUILD) begin
                  state_in = fsc_pkg::ST_BLD_RDW;
               end else if (req_tuser == fsc_pkg::CMD_TEST) begin
                  state_in = fsc_pkg::ST_TST_RD;
               end
            end
         end
         fsc_pkg::ST_BLD_RDW: state_in = fsc_pkg::ST_BLD_RDV;
         fsc_pkg::ST_BLD_RDV: state_in = fsc_pkg::ST_BLD_RAW;
         fsc_pkg::ST_BLD_RAW: begin
            if (j_ff == fsc_pkg::LAST_WORD) begin
               j_in     = '0;
               state_in = fsc_pkg::ST_BLD_MAX;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = fsc_pkg::ST_BLD_RDW;
            end
         end
         fsc_pkg::ST_BLD_MAX: begin
            state_in = status.mx_zero ? fsc_pkg::ST_BLD_ZERO : fsc_pkg::ST_BLD_NORM;
         end
         fsc_pkg::ST_BLD_NORM: begin
            if (status.norm_ok) begin
               state_in = fsc_pkg::ST_BLD_SQ;
            end
         end
         fsc_pkg::ST_BLD_SQ: begin
            if (j_ff == fsc_pkg::LAST_AXIS) begin
               j_in     = '0;
               state_in = fsc_pkg::ST_BLD_SQRT0;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         fsc_pkg::ST_BLD_SQRT0: state_in = fsc_pkg::ST_BLD_SQRT;
         fsc_pkg::ST_BLD_SQRT: begin
            if (status.sqrt_last) begin
               state_in = fsc_pkg::ST_BLD_DIV0;
            end
         end
         fsc_pkg::ST_BLD_DIV0: state_in = fsc_pkg::ST_BLD_DIV;
         fsc_pkg::ST_BLD_DIV: begin
            if (status.div_last) begin
               state_in = fsc_pkg::ST_BLD_DST;
            end
         end
         fsc_pkg::ST_BLD_DST: begin
            if (j_ff == fsc_pkg::LAST_WORD) begin
               j_in     = '0;
               state_in = fsc_pkg::ST_BLD_WR;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = fsc_pkg::ST_BLD_DIV0;
            end
         end
         fsc_pkg::ST_BLD_ZERO: state_in = fsc_pkg::ST_BLD_WR;
         fsc_pkg::ST_BLD_WR: begin
            j_in = '0;
            if (p_ff == fsc_pkg::LAST_PLANE) begin
               state_in = fsc_pkg::ST_IDLE;
            end else begin
               p_in     = p_ff + 3'd1;
               state_in = fsc_pkg::ST_BLD_RDW;
            end
         end
         fsc_pkg::ST_TST_RD: begin
            j_in     = '0;
            state_in = fsc_pkg::ST_TST_MAC;
         end
         fsc_pkg::ST_TST_MAC: begin
            if (j_ff == fsc_pkg::LAST_AXIS) begin
               state_in = fsc_pkg::ST_TST_CMP;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         fsc_pkg::ST_TST_CMP: begin
            if (status.culled || p_ff == fsc_pkg::LAST_PLANE) begin
               state_in = fsc_pkg::ST_TST_OUT;
            end else begin
               p_in     = p_ff + 3'd1;
               state_in = fsc_pkg::ST_TST_RD;
            end
         end
         fsc_pkg::ST_TST_OUT: begin
            if (status.slot_free) begin
               state_in = fsc_pkg::ST_IDLE;
            end
         end
         default: state_in = fsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.plane  = p_ff;
      cmd.step   = j_ff;
      req_tready = 1'b0;
      case (state_ff)
         fsc_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_word = accept && (req_tuser == fsc_pkg::CMD_LOAD);
            cmd.capture   = accept && (req_tuser == fsc_pkg::CMD_TEST);
         end
         fsc_pkg::ST_BLD_RDW: cmd.rd_w = 1'b1;
         fsc_pkg::ST_BLD_RDV: begin
            cmd.lat_w = 1'b1;
            cmd.rd_v  = 1'b1;
         end
         fsc_pkg::ST_BLD_RAW:   cmd.lat_raw   = 1'b1;
         fsc_pkg::ST_BLD_MAX:   cmd.init_max  = 1'b1;
         fsc_pkg::ST_BLD_NORM:  cmd.norm_step = !status.norm_ok;
         fsc_pkg::ST_BLD_SQ:    cmd.sq_step   = 1'b1;
         fsc_pkg::ST_BLD_SQRT0: cmd.sqrt_init = 1'b1;
         fsc_pkg::ST_BLD_SQRT:  cmd.sqrt_step = 1'b1;
         fsc_pkg::ST_BLD_DIV0:  cmd.div_init  = 1'b1;
         fsc_pkg::ST_BLD_DIV:   cmd.div_step  = 1'b1;
         fsc_pkg::ST_BLD_DST:   cmd.div_store = 1'b1;
         fsc_pkg::ST_BLD_ZERO:  cmd.plane_zero = 1'b1;
         fsc_pkg::ST_BLD_WR: begin
            cmd.plane_write  = 1'b1;
            cmd.clear_counts = (p_ff == fsc_pkg::LAST_PLANE);
         end
         fsc_pkg::ST_TST_RD:  cmd.test_rd  = 1'b1;
         fsc_pkg::ST_TST_MAC: cmd.mac_step = 1'b1;
         fsc_pkg::ST_TST_CMP: cmd.test_cmp = 1'b1;
         fsc_pkg::ST_TST_OUT: cmd.emit     = status.slot_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* hw/rtl/fsc_datapath.sv */
// Datapath: matrix and plane stores, normalize, square root, divide, dot product, counters.
module fsc_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fsc_pkg::ctrl_cmd_type              cmd,
   output fsc_pkg::dp_status_type             status,
   input  logic [fsc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               csr_valid,
   input  logic [fsc_pkg::COUNT_W-1:0]        csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fsc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int VW  = VALUE_WIDTH;
   localparam int PW  = 4 * VW;
   localparam int PRW = VW + 32;
   localparam int ACW = VW + 34;
   localparam int CW  = VW + 35;
   localparam logic [63:0] LIM = (64'd1 << (VW - 1)) - 64'd1;
   localparam logic [fsc_pkg::COUNT_W-1:0] CNT_MAX = '1;

   // matrix store
   logic        mvalid_ff [fsc_pkg::MATRIX_WORDS];
   logic        mval_rd_ff;
   logic [3:0]  m_rd_addr;
   logic [31:0] m_rdata, mdata;
   logic [1:0]  row;

   assign row       = 2'(cmd.plane >> 1);
   assign m_rd_addr = cmd.rd_w ? {cmd.step, 2'b11} : {cmd.step, row};

   fsc_ram #(.WIDTH(32), .DEPTH(fsc_pkg::MATRIX_WORDS)) u_matrix (
      .clock   (clock),
      .wr_en   (cmd.load_word),
      .wr_addr (req_tdata[3:0]),
      .wr_data (req_tdata[35:4]),
      .rd_en   (cmd.rd_w || cmd.rd_v),
      .rd_addr (m_rd_addr),
      .rd_data (m_rdata)
   );

   assign mdata = mval_rd_ff ? m_rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fsc_pkg::MATRIX_WORDS; i++) begin
            mvalid_ff[i] <= 1'b0;
         end
      end else if (cmd.load_word) begin
         mvalid_ff[req_tdata[3:0]] <= 1'b1;
      end
      if (cmd.rd_w || cmd.rd_v) begin
         mval_rd_ff <= mvalid_ff[m_rd_addr];
      end
   end

   // raw plane terms and normalization
   logic signed [31:0] w_ff;
   logic signed [32:0] raw_ff [4];
   logic [32:0]        mg_ff [3];
   logic signed [5:0]  k_ff;
   logic [32:0]        mx, raw_mag [4];
   logic               mx_zero;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         raw_mag[i] = raw_ff[i][32] ? 33'(-raw_ff[i]) : 33'(raw_ff[i]);
      end
      mx = mg_ff[0];
      if (mg_ff[1] > mx) mx = mg_ff[1];
      if (mg_ff[2] > mx) mx = mg_ff[2];
      mx_zero = (raw_ff[0] == '0) && (raw_ff[1] == '0) && (raw_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_w) begin
         w_ff <= mdata;
      end
      if (cmd.lat_raw) begin
         raw_ff[cmd.step] <= cmd.plane[0] ? 33'(w_ff) + 33'($signed(mdata))
                                          : 33'(w_ff) - 33'($signed(mdata));
      end
      if (cmd.init_max) begin
         for (int i = 0; i < 3; i++) begin
            mg_ff[i] <= raw_mag[i];
         end
         k_ff <= '0;
      end else if (cmd.norm_step) begin
         if (mx[32:30] != '0) begin
            for (int i = 0; i < 3; i++) begin
               mg_ff[i] <= mg_ff[i] >> 1;
            end
            k_ff <= k_ff - 6'sd1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               mg_ff[i] <= mg_ff[i] << 1;
            end
            k_ff <= k_ff + 6'sd1;
         end
      end
   end

   // sum of squares and square root
   logic [61:0] s_ff;
   logic [63:0] rem_ff, res_ff, t_sum;
   logic [62:0] bit_ff;
   logic [59:0] sq;

   assign sq    = mg_ff[cmd.step][29:0] * mg_ff[cmd.step][29:0];
   assign t_sum = res_ff + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.init_max) begin
         s_ff <= '0;
      end else if (cmd.sq_step) begin
         s_ff <= s_ff + 62'(sq);
      end
      if (cmd.sqrt_init) begin
         rem_ff <= 64'(s_ff);
         res_ff <= '0;
         bit_ff <= 63'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= t_sum) begin
            rem_ff <= rem_ff - t_sum;
            res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [35:0] num_sh_ff, div_num;
   logic [33:0] drem_ff, rn, den;
   logic [63:0] q_ff, q_sat;
   logic [6:0]  dcnt_ff, div_n;
   logic [PW-1:0] prow_ff;
   logic [VW-1:0] q_word;

   assign den = {2'b00, res_ff[31:0]};
   assign rn  = {drem_ff[32:0], num_sh_ff[35]};

   always_comb begin
      case (cmd.step)
         2'd0:    div_num = 36'(mg_ff[0]);
         2'd1:    div_num = 36'(mg_ff[1]);
         2'd2:    div_num = 36'(mg_ff[2]);
         default: div_num = 36'(raw_mag[3]);
      endcase
      div_n  = (cmd.step == fsc_pkg::LAST_WORD) ? 7'(52 + k_ff) : 7'd52;
      q_sat  = (q_ff > LIM) ? LIM : q_ff;
      q_word = raw_ff[cmd.step][32] ? VW'(-q_sat) : VW'(q_sat);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_sh_ff <= div_num;
         drem_ff   <= '0;
         q_ff      <= '0;
         dcnt_ff   <= div_n - 7'd1;
      end else if (cmd.div_step) begin
         if (rn >= den) begin
            drem_ff <= rn - den;
            q_ff    <= {q_ff[62:0], 1'b1};
         end else begin
            drem_ff <= rn;
            q_ff    <= {q_ff[62:0], 1'b0};
         end
         num_sh_ff <= num_sh_ff << 1;
         dcnt_ff   <= dcnt_ff - 7'd1;
      end
      if (cmd.div_store) begin
         prow_ff[cmd.step*VW +: VW] <= q_word;
      end else if (cmd.plane_zero) begin
         prow_ff <= {LIM[VW-1:0], {(3*VW){1'b0}}};
      end
   end

   // plane store
   logic          pvalid_ff [fsc_pkg::NUM_PLANES];
   logic          pval_rd_ff;
   logic [PW-1:0] p_rdata, pdata;

   fsc_ram #(.WIDTH(PW), .DEPTH(fsc_pkg::NUM_PLANES)) u_planes (
      .clock   (clock),
      .wr_en   (cmd.plane_write),
      .wr_addr (cmd.plane),
      .wr_data (prow_ff),
      .rd_en   (cmd.test_rd),
      .rd_addr (cmd.plane),
      .rd_data (p_rdata)
   );

   assign pdata = pval_rd_ff ? p_rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fsc_pkg::NUM_PLANES; i++) begin
            pvalid_ff[i] <= 1'b0;
         end
      end else if (cmd.plane_write) begin
         pvalid_ff[cmd.plane] <= 1'b1;
      end
      if (cmd.test_rd) begin
         pval_rd_ff <= pvalid_ff[cmd.plane];
      end
   end

   // sphere test
   logic signed [31:0]  cx_ff, cy_ff, cz_ff, c_sel;
   logic [30:0]         rad_ff;
   logic signed [VW-1:0] n_sel, d_word;
   logic signed [PRW-1:0] prod;
   logic signed [ACW-1:0] acc_ff, fl;
   logic signed [CW-1:0]  total;
   logic                  vis_ff;

   always_comb begin
      case (cmd.step)
         2'd0:    c_sel = cx_ff;
         2'd1:    c_sel = cy_ff;
         default: c_sel = cz_ff;
      endcase
      n_sel  = $signed(pdata[cmd.step*VW +: VW]);
      d_word = $signed(pdata[3*VW +: VW]);
      prod   = PRW'(n_sel) * PRW'(c_sel);
      fl     = acc_ff >>> 16;
      total  = CW'(fl) + CW'(d_word) + $signed(CW'({1'b0, rad_ff}));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cx_ff  <= $signed(req_tdata[67:36]);
         cy_ff  <= $signed(req_tdata[99:68]);
         cz_ff  <= $signed(req_tdata[131:100]);
         rad_ff <= req_tdata[162:132];
         vis_ff <= 1'b1;
      end else if (cmd.test_cmp && total <= 0) begin
         vis_ff <= 1'b0;
      end
      if (cmd.test_rd) begin
         acc_ff <= '0;
      end else if (cmd.mac_step) begin
         acc_ff <= acc_ff + ACW'(prod);
      end
   end

   // counters, capacity and result register
   logic [fsc_pkg::COUNT_W-1:0] sphere_cnt_ff, hit_cnt_ff, cap_ff, hit_in;
   logic                        rsp_valid_ff, slot_free, stored;
   logic [fsc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign stored    = vis_ff && (hit_cnt_ff < cap_ff);
   assign hit_in    = (vis_ff && hit_cnt_ff != CNT_MAX) ? hit_cnt_ff + 16'd1 : hit_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_cnt_ff <= '0;
         hit_cnt_ff    <= '0;
         cap_ff        <= CNT_MAX;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (cmd.clear_counts) begin
            sphere_cnt_ff <= '0;
            hit_cnt_ff    <= '0;
         end else if (cmd.emit) begin
            hit_cnt_ff <= hit_in;
            if (sphere_cnt_ff != CNT_MAX) begin
               sphere_cnt_ff <= sphere_cnt_ff + 16'd1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.emit) begin
         rsp_data_ff <= {6'd0, hit_in, stored, vis_ff, sphere_cnt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.norm_ok   = (mx[32:30] == '0) && mx[29];
      status.mx_zero   = mx_zero;
      status.sqrt_last = bit_ff[0];
      status.div_last  = (dcnt_ff == '0);
      status.culled    = (total <= 0);
      status.slot_free = slot_free;
   end

endmodule

/* hw/rtl/frustum_sphere_cull.sv */
// Top level of the frustum sphere cull block.
// Takes one command word at a time on req_ and returns one rsp_ word per sphere test.
// A sphere test walks the six stored planes, each with a plane memory read, one
// multiply-accumulate per axis and the compare, and stops at the first culling
// plane; its result is then handed off to the result register.
// A plane build runs one sequencer over the six planes: matrix reads, a
// one-bit-per-cycle normalize, a 32-step square root and four bit-serial divides;
// a plane with a zero normal skips the normalize, square root and divides. The
// result register lets a new word in while the last result waits.
// result_capacity is written on csr_ into a register before it takes effect.
module frustum_sphere_cull #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // matrix_slot, matrix_value, center_x, center_y, center_z, radius, zero pad
   input  logic [167:0] req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sphere_index, visible, stored, hit_total, zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   fsc_pkg::ctrl_cmd_type  cmd;
   fsc_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   fsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fsc_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
